// ===== src/chemical_formula_tokenizer_core_defines.svh =====
// ----------------------------------------------------------------------------
// chemical formula tokenizer assertion macros
// shared property wrappers, clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef CHEMICAL_FORMULA_TOKENIZER_CORE_DEFINES_SVH
`define CHEMICAL_FORMULA_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication
`define CFT_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// character codes, command and status bundles shared by the tokenizer
// ----------------------------------------------------------------------------
package cft_pkg;

   // ascii codes
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // source of an emitted item
   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_PEND = 2'd1,
      EMIT_PROD = 2'd2,
      EMIT_DONE = 2'd3
   } emit_sel_type;

   // done item status
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_UNCLOSED = 2'd2
   } status_code_type;

   typedef struct packed {
      logic            latch;
      logic            start_up;
      logic            start_lo;
      logic            pend_append;
      logic            pend_digit;
      logic            pend_clear;
      logic            store_write;
      logic            group_open;
      logic            group_close;
      logic            mult_digit;
      logic            flush_start;
      logic            flush_next;
      logic            flush_mul;
      logic            flush_done;
      logic            clear_ctx;
      logic            push_last;
      emit_sel_type    emit;
      status_code_type done_status;
   } cmd_type;

   typedef struct packed {
      logic is_up;
      logic is_lo;
      logic is_dig;
      logic is_lparen;
      logic is_rparen;
      logic fin;
      logic cnt_nz;
      logic group_full;
      logic flush_more;
      logic prod_nz;
      logic hold_valid;
      logic out_free;
      logic slot_ok;
   } status_type;

endpackage

// ===== src/cft_ctrl.sv =====
// ----------------------------------------------------------------------------
// cft_ctrl
// parse mode tracking and per-item sequencing of the tokenizer datapath
// ----------------------------------------------------------------------------
module cft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cft_pkg::status_type  status,
   output cft_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      SQ_WAIT    = 6'b000001,
      SQ_FEED    = 6'b000010,
      SQ_FL_READ = 6'b000100,
      SQ_FL_MUL  = 6'b001000,
      SQ_FL_EMIT = 6'b010000,
      SQ_FINAL   = 6'b100000
   } seq_state_type;

   typedef enum logic [7:0] {
      PM_TOP_IDLE   = 8'b00000001,
      PM_TOP_OPEN   = 8'b00000010,
      PM_TOP_ELEM   = 8'b00000100,
      PM_GRP_IDLE   = 8'b00001000,
      PM_GRP_OPEN   = 8'b00010000,
      PM_GRP_ELEM   = 8'b00100000,
      PM_GRP_CLOSED = 8'b01000000,
      PM_ERR        = 8'b10000000
   } parse_mode_type;

   seq_state_type    seq_ff, seq_in, next_seq;
   parse_mode_type   mode_ff, mode_in, disp_mode;
   logic             from_final_ff, from_final_in;
   cft_pkg::cmd_type disp_cmd;
   logic             in_top, in_grp_elem, in_elem, in_open, disp_top, in_group;

   assign in_top      = (mode_ff == PM_TOP_OPEN) || (mode_ff == PM_TOP_ELEM);
   assign in_grp_elem = (mode_ff == PM_GRP_OPEN) || (mode_ff == PM_GRP_ELEM);
   assign in_elem     = in_top || in_grp_elem;
   assign in_open     = (mode_ff == PM_TOP_OPEN) || (mode_ff == PM_GRP_OPEN);
   assign disp_top    = in_top || (mode_ff == PM_TOP_IDLE);
   assign in_group    = in_grp_elem || (mode_ff == PM_GRP_IDLE);
   assign next_seq    = status.fin ? SQ_FINAL : SQ_WAIT;

   assign req_tready = (seq_ff == SQ_WAIT) && (!status.hold_valid || status.out_free);

   // character dispatch from an idle mode
   always_comb begin
      disp_cmd  = '0;
      disp_mode = PM_ERR;
      if (disp_top) begin
         priority if (status.is_up) begin
            disp_cmd.start_up = 1'b1;
            disp_mode         = PM_TOP_OPEN;
         end else if (status.is_lo) begin
            disp_cmd.start_lo = 1'b1;
            disp_mode         = PM_TOP_ELEM;
         end else if (status.is_lparen) begin
            disp_cmd.group_open = 1'b1;
            disp_mode           = PM_GRP_IDLE;
         end else begin
            disp_cmd.clear_ctx = 1'b1;
            disp_mode          = PM_ERR;
         end
      end else begin
         priority if (status.is_up) begin
            disp_cmd.start_up = 1'b1;
            disp_mode         = PM_GRP_OPEN;
         end else if (status.is_lo) begin
            disp_cmd.start_lo = 1'b1;
            disp_mode         = PM_GRP_ELEM;
         end else if (status.is_rparen) begin
            disp_cmd.group_close = 1'b1;
            disp_mode            = PM_GRP_CLOSED;
         end else begin
            disp_cmd.clear_ctx = 1'b1;
            disp_mode          = PM_ERR;
         end
      end
   end

   always_comb begin
      cmd           = '0;
      seq_in        = seq_ff;
      mode_in       = mode_ff;
      from_final_in = from_final_ff;
      unique case (seq_ff)
         SQ_WAIT: begin
            cmd.push_last = status.hold_valid && status.out_free;
            cmd.latch     = req_tvalid && req_tready;
            if (req_tvalid && req_tready) begin
               seq_in = SQ_FEED;
            end
         end
         SQ_FEED: begin
            priority if (in_open && status.is_lo) begin
               cmd.pend_append = 1'b1;
               mode_in         = in_top ? PM_TOP_ELEM : PM_GRP_ELEM;
               seq_in          = next_seq;
            end else if (in_elem && status.is_dig) begin
               cmd.pend_digit = 1'b1;
               mode_in        = in_top ? PM_TOP_ELEM : PM_GRP_ELEM;
               seq_in         = next_seq;
            end else if (in_top) begin
               // element ends: send it out, then take the char from idle
               if (!status.cnt_nz || status.slot_ok) begin
                  cmd            = disp_cmd;
                  cmd.pend_clear = 1'b1;
                  cmd.emit       = status.cnt_nz ? cft_pkg::EMIT_PEND : cft_pkg::EMIT_NONE;
                  mode_in        = disp_mode;
                  seq_in         = next_seq;
               end
            end else if (in_grp_elem) begin
               if (status.cnt_nz && status.group_full) begin
                  cmd.clear_ctx = 1'b1;
                  mode_in       = PM_ERR;
                  seq_in        = next_seq;
               end else begin
                  cmd             = disp_cmd;
                  cmd.pend_clear  = 1'b1;
                  cmd.store_write = status.cnt_nz;
                  mode_in         = disp_mode;
                  seq_in          = next_seq;
               end
            end else if (mode_ff == PM_GRP_CLOSED) begin
               if (status.is_dig) begin
                  cmd.mult_digit = 1'b1;
                  seq_in         = next_seq;
               end else begin
                  cmd.flush_start = 1'b1;
                  from_final_in   = 1'b0;
                  seq_in          = SQ_FL_READ;
               end
            end else if ((mode_ff == PM_TOP_IDLE) || (mode_ff == PM_GRP_IDLE)) begin
               cmd     = disp_cmd;
               mode_in = disp_mode;
               seq_in  = next_seq;
            end else begin
               seq_in = next_seq;
            end
         end
         SQ_FL_READ: begin
            if (status.flush_more) begin
               seq_in = SQ_FL_MUL;
            end else begin
               cmd.flush_done = 1'b1;
               mode_in        = PM_TOP_IDLE;
               seq_in         = from_final_ff ? SQ_FINAL : SQ_FEED;
            end
         end
         SQ_FL_MUL: begin
            cmd.flush_mul = 1'b1;
            seq_in        = SQ_FL_EMIT;
         end
         SQ_FL_EMIT: begin
            if (!status.prod_nz) begin
               cmd.flush_next = 1'b1;
               seq_in         = SQ_FL_READ;
            end else if (status.slot_ok) begin
               cmd.emit       = cft_pkg::EMIT_PROD;
               cmd.flush_next = 1'b1;
               seq_in         = SQ_FL_READ;
            end
         end
         SQ_FINAL: begin
            if (in_top) begin
               if (!status.cnt_nz || status.slot_ok) begin
                  cmd.pend_clear = 1'b1;
                  cmd.emit       = status.cnt_nz ? cft_pkg::EMIT_PEND : cft_pkg::EMIT_NONE;
                  mode_in        = PM_TOP_IDLE;
               end
            end else if (mode_ff == PM_GRP_CLOSED) begin
               cmd.flush_start = 1'b1;
               from_final_in   = 1'b1;
               seq_in          = SQ_FL_READ;
            end else if (status.slot_ok) begin
               cmd.emit        = cft_pkg::EMIT_DONE;
               cmd.done_status = (mode_ff == PM_ERR) ? cft_pkg::STATUS_BAD_CHAR :
                                 in_group ? cft_pkg::STATUS_UNCLOSED : cft_pkg::STATUS_OK;
               cmd.clear_ctx   = 1'b1;
               mode_in         = PM_TOP_IDLE;
               seq_in          = SQ_WAIT;
            end
         end
         default: begin
            seq_in  = SQ_WAIT;
            mode_in = PM_TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SQ_WAIT;
         mode_ff       <= PM_TOP_IDLE;
         from_final_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         mode_ff       <= mode_in;
         from_final_ff <= from_final_in;
      end
   end

endmodule

// ===== src/cft_dpath.sv =====
// ----------------------------------------------------------------------------
// cft_dpath
// character register, pending element, group buffer, flush multiplier and
// the hold and output registers of the result stream
// ----------------------------------------------------------------------------
module cft_dpath #(
   parameter int GROUP_DEPTH = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cft_pkg::cmd_type     cmd,
   output cft_pkg::status_type  status,
   input  logic [7:0]           req_ch,
   input  logic                 req_final,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int CB = COUNT_BITS;
   localparam int PW = 2 * COUNT_BITS;
   localparam int EW = 16 + COUNT_BITS;
   localparam int IW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
   localparam int FW = $clog2(GROUP_DEPTH + 1);

   function automatic logic [15:0] sat_to_16(input logic [31:0] v);
      sat_to_16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
   endfunction

   logic [7:0]    ch_ff;
   logic          fin_ff;
   logic [15:0]   pend_sym_ff, pend_sym_in;
   logic [CB-1:0] pend_cnt_ff, pend_cnt_in;
   logic          seen_ff, seen_in;
   logic [CB-1:0] mult_ff, mult_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [EW-1:0] store_mem [GROUP_DEPTH];
   logic [EW-1:0] rd_ff;
   logic [PW-1:0] prod_ff;
   logic [15:0]   fsym_ff;

   logic          hold_valid_ff, hold_valid_in;
   logic [15:0]   hold_sym_ff, hold_cnt_ff;
   logic          hold_done_ff;
   logic [1:0]    hold_status_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_sym_ff, rsp_cnt_ff;
   logic          rsp_done_ff, rsp_last_ff;
   logic [1:0]    rsp_status_ff;

   logic [CB-1:0] acc_src, acc_sat, fin_cnt, mult_eff, prod_sat;
   logic [CB+3:0] acc_ext, acc_step;
   logic [15:0]   emit_sym, emit_cnt;
   logic          emit_done, emit_valid, rsp_load, out_free;
   logic [1:0]    emit_status;

   // character classes
   assign status.is_up     = (ch_ff >= cft_pkg::CH_UPPER_A) && (ch_ff <= cft_pkg::CH_UPPER_Z);
   assign status.is_lo     = (ch_ff >= cft_pkg::CH_LOWER_A) && (ch_ff <= cft_pkg::CH_LOWER_Z);
   assign status.is_dig    = (ch_ff >= cft_pkg::CH_DIGIT_0) && (ch_ff <= cft_pkg::CH_DIGIT_9);
   assign status.is_lparen = (ch_ff == cft_pkg::CH_LPAREN);
   assign status.is_rparen = (ch_ff == cft_pkg::CH_RPAREN);
   assign status.fin       = fin_ff;

   // decimal accumulate, shared by element count and group multiplier
   assign acc_src  = cmd.mult_digit ? mult_ff : pend_cnt_ff;
   assign acc_ext  = {4'b0000, acc_src};
   assign acc_step = (acc_ext << 3) + (acc_ext << 1) + {{CB{1'b0}}, ch_ff[3:0]};
   assign acc_sat  = (|acc_step[CB+3:CB]) ? {CB{1'b1}} : acc_step[CB-1:0];

   // missing count means one
   assign fin_cnt           = seen_ff ? pend_cnt_ff : CB'(1);
   assign status.cnt_nz     = !seen_ff || (pend_cnt_ff != '0);
   assign status.group_full = (fill_ff == FW'(GROUP_DEPTH));
   assign status.flush_more = (idx_ff < fill_ff);

   assign mult_eff       = seen_ff ? mult_ff : CB'(1);
   assign prod_sat       = (|prod_ff[PW-1:CB]) ? {CB{1'b1}} : prod_ff[CB-1:0];
   assign status.prod_nz = (prod_ff != '0);

   always_comb begin
      pend_sym_in = pend_sym_ff;
      priority if (cmd.start_up) begin
         pend_sym_in = {ch_ff, 8'h00};
      end else if (cmd.start_lo) begin
         pend_sym_in = {ch_ff - cft_pkg::CASE_OFFSET, 8'h00};
      end else if (cmd.pend_append) begin
         pend_sym_in = {pend_sym_ff[15:8], ch_ff};
      end else if (cmd.pend_clear || cmd.clear_ctx) begin
         pend_sym_in = '0;
      end

      pend_cnt_in = pend_cnt_ff;
      priority if (cmd.start_up || cmd.start_lo || cmd.pend_clear || cmd.clear_ctx) begin
         pend_cnt_in = '0;
      end else if (cmd.pend_digit) begin
         pend_cnt_in = acc_sat;
      end

      seen_in = seen_ff;
      priority if (cmd.start_up || cmd.start_lo || cmd.pend_clear || cmd.clear_ctx ||
                   cmd.group_close || cmd.flush_done) begin
         seen_in = 1'b0;
      end else if (cmd.pend_digit || cmd.mult_digit) begin
         seen_in = 1'b1;
      end

      mult_in = mult_ff;
      priority if (cmd.clear_ctx || cmd.group_close || cmd.flush_done) begin
         mult_in = '0;
      end else if (cmd.mult_digit) begin
         mult_in = acc_sat;
      end

      fill_in = fill_ff;
      priority if (cmd.clear_ctx || cmd.group_open || cmd.flush_done) begin
         fill_in = '0;
      end else if (cmd.store_write) begin
         fill_in = fill_ff + FW'(1);
      end

      idx_in = idx_ff;
      priority if (cmd.flush_start) begin
         idx_in = '0;
      end else if (cmd.flush_next) begin
         idx_in = idx_ff + FW'(1);
      end
   end

   // result source select
   always_comb begin
      emit_sym    = '0;
      emit_cnt    = '0;
      emit_done   = 1'b0;
      emit_status = '0;
      unique case (cmd.emit)
         cft_pkg::EMIT_NONE: begin
            emit_done = 1'b0;
         end
         cft_pkg::EMIT_PEND: begin
            emit_sym = pend_sym_ff;
            emit_cnt = sat_to_16(32'(fin_cnt));
         end
         cft_pkg::EMIT_PROD: begin
            emit_sym = fsym_ff;
            emit_cnt = sat_to_16(32'(prod_sat));
         end
         cft_pkg::EMIT_DONE: begin
            emit_done   = 1'b1;
            emit_status = cmd.done_status;
         end
      endcase
   end

   // the hold stage keeps the newest item back until it is known whether it ends
   // the run of its input item
   assign emit_valid     = (cmd.emit != cft_pkg::EMIT_NONE);
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign rsp_load       = (emit_valid && hold_valid_ff) || cmd.push_last;
   assign rsp_valid_in   = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign hold_valid_in  = emit_valid ? 1'b1 : (cmd.push_last ? 1'b0 : hold_valid_ff);
   assign status.hold_valid = hold_valid_ff;
   assign status.out_free   = out_free;
   assign status.slot_ok    = !hold_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_sym_ff   <= '0;
         pend_cnt_ff   <= '0;
         seen_ff       <= 1'b0;
         mult_ff       <= '0;
         fill_ff       <= '0;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_sym_ff   <= pend_sym_in;
         pend_cnt_ff   <= pend_cnt_in;
         seen_ff       <= seen_in;
         mult_ff       <= mult_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ch_ff  <= req_ch;
         fin_ff <= req_final;
      end
      if (cmd.flush_mul) begin
         prod_ff <= PW'(rd_ff[CB-1:0]) * PW'(mult_eff);
         fsym_ff <= rd_ff[EW-1:CB];
      end
      if (emit_valid) begin
         hold_sym_ff    <= emit_sym;
         hold_cnt_ff    <= emit_cnt;
         hold_done_ff   <= emit_done;
         hold_status_ff <= emit_status;
      end
      if (rsp_load) begin
         rsp_sym_ff    <= hold_sym_ff;
         rsp_cnt_ff    <= hold_cnt_ff;
         rsp_done_ff   <= hold_done_ff;
         rsp_status_ff <= hold_status_ff;
         rsp_last_ff   <= cmd.push_last;
      end
   end

   // group buffer, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.store_write) begin
         store_mem[fill_ff[IW-1:0]] <= {pend_sym_ff, fin_cnt};
      end
      rd_ff <= store_mem[idx_ff[IW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_sym_ff[7:0], rsp_sym_ff[15:8]};
   assign rsp_tuser  = {rsp_status_ff, rsp_done_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/chemical_formula_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// chemical_formula_tokenizer_core: formula characters in, element tokens out
// each character is accepted, then decoded; the next is taken only once that is done.
// The character after a closed group first flushes the group buffer (read, multiply,
// send per buffered token); the final character then sends the pending element, or
// flushes a closed group, and then the done item. The last item of a character leaves
// the hold register when the sequencer is back waiting and the output register is free
// reset: synchronous, clears sequencer, parse mode, counters and output valid
// ----------------------------------------------------------------------------
`include "chemical_formula_tokenizer_core_defines.svh"

module chemical_formula_tokenizer_core #(
   parameter int GROUP_DEPTH = 16,   // group token buffer entries
   parameter int COUNT_BITS  = 16    // internal count width, saturating
) (
   input  logic        clock,
   input  logic        reset,

   // formula characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] ch
   input  logic        req_tlast,    // final_char

   // element tokens and done items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] sym_first, [15:8] sym_second, [31:16] atom_count
   output logic [2:0]  rsp_tuser,    // [0] done_res, [2:1] status
   output logic        rsp_tlast     // run_last
);

   // controller to datapath commands and returning status
   cft_pkg::cmd_type    ctl_cmd;
   cft_pkg::status_type dp_status;

   // controller: tracks where the parser sits in the formula (top level,
   // inside a group, after a group close, error) and steps each item through
   // decode, group flush and formula end
   cft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (ctl_cmd)
   );

   // datapath: pending element, decimal count accumulator, group buffer with
   // its multiplier, and the hold plus output registers; the hold stage is what
   // lets the last item of each character carry tlast
   cft_dpath #(
      .GROUP_DEPTH (GROUP_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctl_cmd),
      .status     (dp_status),
      .req_ch     (req_tdata),
      .req_final  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // an item only enters the hold stage when the previous one can move on
   `CFT_ASSERT_NOW(a_emit_has_slot, ctl_cmd.emit != cft_pkg::EMIT_NONE, dp_status.slot_ok, "item emitted without a free slot")

   // the group buffer is never written past its depth
   `CFT_ASSERT_NOW(a_store_in_range, ctl_cmd.store_write, !dp_status.group_full, "group buffer write past depth")

   // one character is worked on at a time
   `CFT_ASSERT_NEXT(a_single_char, req_tvalid && req_tready, !req_tready, "character accepted while busy")

endmodule
